[hdl/fms_pkg.sv]
`default_nettype none

package fms_pkg;

	// capacity of one set
	localparam int MAX_ITEMS = 64;
	localparam int ADDR_W    = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
	localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
	localparam int SUM_W     = CNT_W + 1;
	localparam int DATA_W    = 32;

	// sequencer states
	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_PASS   = 5'b00010,
		ST_MERGE  = 5'b00100,
		ST_ESTART = 5'b01000,
		ST_EMIT   = 5'b10000
	} fms_state_t;

	// shared request to both banks; each bank has its own write enable
	typedef struct packed {
		logic              we0;
		logic              we1;
		logic [ADDR_W-1:0] waddr;
		logic [DATA_W-1:0] wdata;
		logic [ADDR_W-1:0] raddr_a;
		logic [ADDR_W-1:0] raddr_b;
	} mem_req_t;

	// sequencer status for checks at the top level
	typedef struct packed {
		logic             merging;
		logic [CNT_W-1:0] cnt;
		logic [CNT_W-1:0] a;
		logic [CNT_W-1:0] b;
		logic [CNT_W-1:0] mid;
		logic [CNT_W-1:0] hi;
		logic [CNT_W-1:0] k;
	} seq_stat_t;

	// monotone key: negative values invert fully, positive flip the sign
	function automatic logic [DATA_W-1:0] order_key(input logic [DATA_W-1:0] bits);
		return bits[DATA_W-1] ? ~bits : {1'b1, bits[DATA_W-2:0]};
	endfunction

endpackage

`default_nettype wire

[hdl/fms_ram.sv]
`default_nettype none

module fms_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic      [WIDTH-1:0]         rdata_a,
	output logic      [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, two registered read ports
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

`default_nettype wire

[hdl/fms_seq.sv]
`default_nettype none

module fms_seq
	import fms_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire logic [DATA_W-1:0] s_tdata,
	input  wire logic              s_tlast,
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	output logic      [DATA_W-1:0] m_tdata,
	output logic                   m_tlast,
	output logic                   m_tuser,
	output mem_req_t               req,
	input  wire logic [DATA_W-1:0] rd0_a,
	input  wire logic [DATA_W-1:0] rd0_b,
	input  wire logic [DATA_W-1:0] rd1_a,
	input  wire logic [DATA_W-1:0] rd1_b,
	output seq_stat_t              stat
);

	fms_state_t       state_q, state_n;
	logic [CNT_W-1:0] cnt_q, cnt_n;
	logic             drop_q, drop_n;
	logic             src_q, src_n;
	logic [CNT_W-1:0] w_q, w_n;
	logic [CNT_W-1:0] a_q, a_n, b_q, b_n, mid_q, mid_n, hi_q, hi_n, k_q, k_n;
	logic             out_v_q;
	logic [DATA_W-1:0] out_d_q;
	logic             out_l_q, out_u_q;

	logic              acc, room, take_b, va, vb, pair_end, pass_end, out_load, out_free;
	logic [DATA_W-1:0] rd_a, rd_b, merged;
	logic [SUM_W-1:0]  w2;

	// clamp a run bound to the set size
	function automatic logic [CNT_W-1:0] clip(input logic [SUM_W-1:0] s,
	                                          input logic [CNT_W-1:0] n);
		return (s > {1'b0, n}) ? n : s[CNT_W-1:0];
	endfunction

	assign s_tready = (state_q == ST_IDLE);
	assign acc      = s_tvalid && s_tready;
	assign room     = cnt_q < CNT_W'(MAX_ITEMS);

	// heads of both runs come straight from the source bank
	assign rd_a     = src_q ? rd1_a : rd0_a;
	assign rd_b     = src_q ? rd1_b : rd0_b;
	assign va       = a_q < mid_q;
	assign vb       = b_q < hi_q;
	assign take_b   = vb && (!va || (order_key(rd_b) < order_key(rd_a)));
	assign merged   = take_b ? rd_b : rd_a;
	assign pair_end = (k_q + CNT_W'(1)) == hi_q;
	assign pass_end = pair_end && (hi_q == cnt_q);
	assign w2       = {1'b0, w_q} << 1;
	assign out_free = !out_v_q || m_tready;

	// next-state and pointer logic
	always_comb begin
		state_n  = state_q;
		cnt_n    = cnt_q;
		drop_n   = drop_q;
		src_n    = src_q;
		w_n      = w_q;
		a_n      = a_q;
		b_n      = b_q;
		mid_n    = mid_q;
		hi_n     = hi_q;
		k_n      = k_q;
		out_load = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (acc) begin
					if (room) begin
						cnt_n = cnt_q + CNT_W'(1);
					end else begin
						drop_n = 1'b1;
					end
					if (s_tlast) begin
						w_n     = CNT_W'(1);
						src_n   = 1'b0;
						state_n = (cnt_n == CNT_W'(1)) ? ST_ESTART : ST_PASS;
					end
				end
			end
			ST_PASS: begin
				a_n     = '0;
				k_n     = '0;
				mid_n   = clip({1'b0, w_q}, cnt_q);
				hi_n    = clip(w2, cnt_q);
				b_n     = mid_n;
				state_n = ST_MERGE;
			end
			ST_MERGE: begin
				k_n = k_q + CNT_W'(1);
				if (pass_end) begin
					src_n   = !src_q;
					w_n     = w2[CNT_W-1:0];
					state_n = (w2 >= {1'b0, cnt_q}) ? ST_ESTART : ST_PASS;
				end else if (pair_end) begin
					a_n   = hi_q;
					mid_n = clip({1'b0, hi_q} + {1'b0, w_q}, cnt_q);
					hi_n  = clip({1'b0, hi_q} + w2, cnt_q);
					b_n   = mid_n;
				end else begin
					a_n = a_q + CNT_W'(!take_b);
					b_n = b_q + CNT_W'(take_b);
				end
			end
			ST_ESTART: begin
				a_n     = '0;
				state_n = ST_EMIT;
			end
			ST_EMIT: begin
				if (out_free) begin
					out_load = 1'b1;
					a_n      = a_q + CNT_W'(1);
					if (a_q == cnt_q - CNT_W'(1)) begin
						state_n = ST_IDLE;
						cnt_n   = '0;
						drop_n  = 1'b0;
					end
				end
			end
			default: state_n = ST_IDLE;
		endcase
	end

	// memory requests: load fills bank 0, merge writes the other bank
	always_comb begin
		req.we0     = (acc && room) || ((state_q == ST_MERGE) && src_q);
		req.we1     = (state_q == ST_MERGE) && !src_q;
		req.waddr   = (state_q == ST_MERGE) ? k_q[ADDR_W-1:0] : cnt_q[ADDR_W-1:0];
		req.wdata   = (state_q == ST_MERGE) ? merged : s_tdata;
		req.raddr_a = a_n[ADDR_W-1:0];
		req.raddr_b = b_n[ADDR_W-1:0];
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			drop_q  <= 1'b0;
			src_q   <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			state_q <= state_n;
			cnt_q   <= cnt_n;
			drop_q  <= drop_n;
			src_q   <= src_n;
			if (out_load) begin
				out_v_q <= 1'b1;
			end else if (m_tready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// pointers and output payload
	always_ff @(posedge clk) begin
		w_q   <= w_n;
		a_q   <= a_n;
		b_q   <= b_n;
		mid_q <= mid_n;
		hi_q  <= hi_n;
		k_q   <= k_n;
		if (out_load) begin
			out_d_q <= rd_a;
			out_l_q <= (a_q == cnt_q - CNT_W'(1));
			out_u_q <= drop_q;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = out_d_q;
	assign m_tlast  = out_l_q;
	assign m_tuser  = out_u_q;

	always_comb begin
		stat.merging = (state_q == ST_MERGE);
		stat.cnt     = cnt_q;
		stat.a       = a_q;
		stat.b       = b_q;
		stat.mid     = mid_q;
		stat.hi      = hi_q;
		stat.k       = k_q;
	end

endmodule

`default_nettype wire

[hdl/float_merge_sorter.sv]
// Collects up to MAX_ITEMS floats, merge-sorts them on tlast, streams them out ascending.
// Load: one item per cycle. Sort: ceil(log2 n) passes, each a setup step and then
// one merge step per cycle on two dual-read bank RAMs; then a start step and one result
// per cycle while m_tready is high.
// Reset (arst_n low, asynchronous) empties the set and clears the drop flag and output;
// the RAM contents are not cleared.
`default_nettype none

module float_merge_sorter
	import fms_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire logic [DATA_W-1:0] s_tdata,   // [31:0] value
	input  wire logic              s_tlast,
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	output logic      [DATA_W-1:0] m_tdata,   // [31:0] sorted_value
	output logic                   m_tlast,
	output logic                   m_tuser    // [0] overflow
);

	mem_req_t          req;
	seq_stat_t         stat;
	logic [DATA_W-1:0] rd0_a, rd0_b, rd1_a, rd1_b;

	// bank 0 holds the loaded set; the banks swap source and merge-buffer roles each pass
	fms_ram #(.WIDTH(DATA_W), .DEPTH(MAX_ITEMS)) u_bank0 (
		.clk     (clk),
		.we      (req.we0),
		.waddr   (req.waddr),
		.wdata   (req.wdata),
		.raddr_a (req.raddr_a),
		.raddr_b (req.raddr_b),
		.rdata_a (rd0_a),
		.rdata_b (rd0_b)
	);

	fms_ram #(.WIDTH(DATA_W), .DEPTH(MAX_ITEMS)) u_bank1 (
		.clk     (clk),
		.we      (req.we1),
		.waddr   (req.waddr),
		.wdata   (req.wdata),
		.raddr_a (req.raddr_a),
		.raddr_b (req.raddr_b),
		.rdata_a (rd1_a),
		.rdata_b (rd1_b)
	);

	fms_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser),
		.req      (req),
		.rd0_a    (rd0_a),
		.rd0_b    (rd0_b),
		.rd1_a    (rd1_a),
		.rd1_b    (rd1_b),
		.stat     (stat)
	);

	// no input is taken while a merge runs
	a_no_load_in_merge: assert property (@(posedge clk) disable iff (!arst_n)
		stat.merging |-> !s_tready)
		else $error("input ready during merge");

	// merge write pointer stays inside the current run pair
	a_k_in_pair: assert property (@(posedge clk) disable iff (!arst_n)
		stat.merging |-> (stat.k < stat.hi))
		else $error("merge write pointer past run end");

	// read pointers never pass their run bounds
	a_runs_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		stat.merging |-> ((stat.a <= stat.mid) && (stat.b <= stat.hi) && (stat.hi <= stat.cnt)))
		else $error("run pointer out of bounds");

	// the stored count never exceeds capacity
	a_cnt_cap: assert property (@(posedge clk) disable iff (!arst_n)
		stat.cnt <= CNT_W'(MAX_ITEMS))
		else $error("element count above capacity");

endmodule

`default_nettype wire
